/* src/nclca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nclca_pkg
// Shared constants and types of the command line assembler.
// ----------------------------------------------------------------------------
package nclca_pkg;

	localparam int LINE_STORE = 64;
	localparam int CNT_W      = $clog2(LINE_STORE);
	localparam int ADDR_W     = CNT_W + 1;
	localparam int BYTE_W     = 8;
	localparam int MOL_W      = 7;

	localparam logic [BYTE_W-1:0] CH_LF = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR = 8'd13;

	localparam logic [CNT_W-1:0] CNT_CAP   = CNT_W'(LINE_STORE - 1);
	localparam logic [MOL_W-1:0] MOL_RESET = MOL_W'(64);

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] len;
	} desc_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef enum logic {
		BK_IDLE,
		BK_OUT
	} back_state_t;

endpackage

/* src/nclca_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nclca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nclca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/nclca_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nclca_front
// Takes raw bytes, fills the current line bank and queues closed lines.
// ----------------------------------------------------------------------------
module nclca_front
	import nclca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic [MOL_W-1:0]  max_out_len,
	input  release_t          rel,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [BYTE_W-1:0] wr_data,
	output logic              push,
	output desc_t             push_desc
);

	logic             wb_q;
	logic [1:0]       owned_q;
	logic [CNT_W-1:0] count_q;
	logic             xfer;
	logic             close;
	logic [CNT_W-1:0] len;

	assign in_stall = owned_q[wb_q];
	assign xfer     = in_valid && !in_stall;
	assign close    = (in_byte == CH_LF) || (count_q == CNT_CAP);

	always_comb begin
		if ({1'b0, count_q} < max_out_len) begin
			len = count_q;
		end else if (max_out_len == '0) begin
			len = '0;
		end else begin
			len = CNT_W'(max_out_len - 1'b1);
		end
	end

	assign wr_en          = xfer && !close && (in_byte != CH_CR);
	assign wr_addr        = {wb_q, count_q};
	assign wr_data        = in_byte;
	assign push           = xfer && close && (len != '0);
	assign push_desc.bank = wb_q;
	assign push_desc.len  = len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q    <= 1'b0;
			owned_q <= '0;
			count_q <= '0;
		end else begin
			if (rel.valid) begin
				owned_q[rel.bank] <= 1'b0;
			end
			if (push) begin
				owned_q[wb_q] <= 1'b1;
				wb_q          <= !wb_q;
			end
			if (xfer && close) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

/* src/nclca_desc_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nclca_desc_fifo
// Two-entry queue of closed line descriptors between front and back.
// ----------------------------------------------------------------------------
module nclca_desc_fifo
	import nclca_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output logic  empty,
	output logic  full,
	output desc_t head
);

	desc_t      ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign empty   = (cnt_q == 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign head    = ent_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

/* src/nclca_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nclca_back
// Reads a queued line from its bank and sends it out one character a transfer.
// ----------------------------------------------------------------------------
module nclca_back
	import nclca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  desc_t             q_head,
	output logic              q_pop,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              last_of_line,
	output release_t          rel,
	output logic              cur_bank
);

	back_state_t      st_q;
	back_state_t      st_d;
	logic             bank_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] idx_q;
	logic             last;
	logic             step;

	assign last         = (idx_q == len_q - 1'b1);
	assign last_of_line = last;
	assign cur_bank     = bank_q;

	always_comb begin
		st_d      = st_q;
		q_pop     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = {q_head.bank, {CNT_W{1'b0}}};
		out_valid = 1'b0;
		rel       = '0;
		step      = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					rd_en = 1'b1;
					st_d  = BK_OUT;
				end
			end
			BK_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (last) begin
						rel.valid = 1'b1;
						rel.bank  = bank_q;
						if (!q_empty) begin
							q_pop = 1'b1;
							rd_en = 1'b1;
						end else begin
							st_d = BK_IDLE;
						end
					end else begin
						step    = 1'b1;
						rd_en   = 1'b1;
						rd_addr = {bank_q, idx_q + 1'b1};
					end
				end
			end
			default: begin
				st_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_IDLE;
			bank_q <= 1'b0;
			len_q  <= '0;
			idx_q  <= '0;
		end else begin
			st_q <= st_d;
			if (q_pop) begin
				bank_q <= q_head.bank;
				len_q  <= q_head.len;
				idx_q  <= '0;
			end else if (step) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

/* src/newline_command_line_assembler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newline_command_line_assembler_core
// Frames a received byte stream into command lines, dropping carriage returns.
// ----------------------------------------------------------------------------
// input: one byte per cycle into one of two line banks; stalls only while both
//   banks hold lines still waiting to be sent
// output: a closed line is queued, then popped by the back when idle and its bank read;
//   then one character per cycle while out_stall is low, from the registered bank read port
// reset: count, queue, bank ownership and sender cleared; max_out_len is 64
module newline_command_line_assembler_core
	import nclca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MOL_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last_of_line
);

	logic [MOL_W-1:0]  mol_q;
	release_t          rel;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              push;
	desc_t             push_desc;
	logic              q_pop;
	logic              q_empty;
	logic              q_full;
	desc_t             q_head;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              cur_bank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mol_q <= MOL_RESET;
		end else if (cfg_we) begin
			mol_q <= cfg_wdata;
		end
	end

	nclca_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.max_out_len (mol_q),
		.rel         (rel),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.push        (push),
		.push_desc   (push_desc)
	);

	nclca_desc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (q_pop),
		.empty     (q_empty),
		.full      (q_full),
		.head      (q_head)
	);

	nclca_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.last_of_line (last_of_line),
		.rel          (rel),
		.cur_bank     (cur_bank)
	);

	nclca_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (2 * LINE_STORE)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (out_byte)
	);

	// a line is never queued while the queue is full
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("line queued while descriptor queue full");

	// the front never writes the bank being sent
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && wr_en) |-> (wr_addr[ADDR_W-1] != cur_bank))
		else $error("write into bank under transfer");

	// a pop only happens with a queued line
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("pop from empty descriptor queue");

	// a bank is released only at the final character transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> (out_valid && !out_stall && last_of_line))
		else $error("bank released outside final transfer");

endmodule
